// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/sitd_pkg.sv =====
`default_nettype none

package sitd_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RADIX_IN_W  = 5;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_ARG_W = 6;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'd65;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_LINE_END
  } sitd_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_ARG_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_ARG_W'(10)) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_ALPHA + dx - CHAR_W'(10);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_integer_to_digit_string.sv =====
`default_nettype none

// Channel   Dir  tdata bits                           tuser  tlast
// s_axis    in   [31:0] value, [36:32] radix, pad to 40  -      -
// m_axis    out  [6:0] char_code, pad to 8           -      last (line feed)
//
// One request at a time; s_axis_tready_o is high only while idle.
// Each digit passes through the shared bit-serial divider (start, 32 steps
// and store); a number has 32 binary digits at most.
// A stalled m_axis only holds the sequencer at the next character.
// Reset is asynchronous, active low; the digit store needs no clearing.
module signed_integer_to_digit_string #(
  parameter int unsigned MAX_DIGITS = 32,
  parameter int unsigned MAX_RADIX  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [31:0] value, [36:32] radix, [39:37] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,  // [6:0] char_code, [7] zero
  output logic             m_axis_tlast_o
);

  import sitd_pkg::*;

  localparam int unsigned RADIX_W = $clog2(MAX_RADIX + 1);
  localparam int unsigned DIGIT_W = $clog2(MAX_RADIX);
  localparam int unsigned CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_DIGITS);
  localparam int unsigned CMP_W   = (RADIX_W > RADIX_IN_W) ? RADIX_W : RADIX_IN_W;

  sitd_state_e state_q, state_d;

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cnt_dec;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_free;

  logic [VALUE_W-1:0] in_value;
  logic [CMP_W-1:0]   in_radix;
  logic [CMP_W-1:0]   radix_sat;
  logic               in_neg;
  logic               accept;

  logic               div_start;
  logic               div_done;
  logic [VALUE_W-1:0] div_quot;
  logic [RADIX_W-1:0] div_rem;

  logic               ram_wr;
  logic               ram_rd;
  logic [DIGIT_W-1:0] ram_rdata;

  assign in_value = s_axis_tdata_i[VALUE_W-1:0];
  assign in_radix = CMP_W'(s_axis_tdata_i[VALUE_W +: RADIX_IN_W]);
  assign in_neg   = in_value[VALUE_W-1];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cnt_dec  = cnt_q - CNT_W'(1);

  always_comb begin
    if (in_radix < CMP_W'(2)) begin
      radix_sat = CMP_W'(2);
    end else if (in_radix > CMP_W'(MAX_RADIX)) begin
      radix_sat = CMP_W'(MAX_RADIX);
    end else begin
      radix_sat = in_radix;
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    radix_d     = radix_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    div_start   = 1'b0;
    ram_wr      = 1'b0;
    ram_rd      = 1'b0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          mag_d   = in_neg ? (~in_value + VALUE_W'(1)) : in_value;
          radix_d = RADIX_W'(radix_sat);
          cnt_d   = '0;
          state_d = in_neg ? ST_SIGN : ST_DIV_GO;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CH_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          // zero still yields one digit, so the loop always runs at least once
          ram_wr = 1'b1;
          mag_d  = div_quot;
          cnt_d  = cnt_q + CNT_W'(1);
          if (div_quot == '0 || cnt_q == CNT_W'(MAX_DIGITS - 1)) begin
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_EMIT_RD: begin
        if (cnt_q == '0) begin
          state_d = ST_LINE_END;
        end else begin
          ram_rd  = 1'b1;
          cnt_d   = cnt_dec;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(DIGIT_ARG_W'(ram_rdata));
          out_last_d  = 1'b0;
          state_d     = ST_EMIT_RD;
        end
      end
      ST_LINE_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CH_LF;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mag_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  sitd_divider #(
    .RADIX_W (RADIX_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  sitd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (div_rem[DIGIT_W-1:0]),
    .rd_en_i   (ram_rd),
    .rd_addr_i (cnt_dec[ADDR_W-1:0]),
    .rd_data_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_busy_after_req, accept |=> !s_axis_tready_o, "new request taken mid-number")
  `ASSERT_CLK(a_last_is_lf, m_axis_tvalid_o && m_axis_tlast_o |-> out_char_q == CH_LF,
              "last flag on a non line-feed character")
  `ASSERT_CLK(a_cnt_range, cnt_q <= CNT_W'(MAX_DIGITS), "digit count beyond store depth")
  `ASSERT_ALWAYS(a_reset_quiet, $rose(rst_ni) |-> !m_axis_tvalid_o, "output valid out of reset")

endmodule

`default_nettype wire

// ===== rtl/sitd_ram.sv =====
`default_nettype none

module sitd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sitd_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sitd_divider #(
  parameter int unsigned RADIX_W = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [sitd_pkg::VALUE_W-1:0]   dividend_i,
  input  wire logic [RADIX_W-1:0]             divisor_i,
  output logic      [sitd_pkg::VALUE_W-1:0]   quotient_o,
  output logic      [RADIX_W-1:0]             remainder_o,
  output logic                                done_o
);

  import sitd_pkg::*;

  localparam int unsigned STEP_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] dvd_q, dvd_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] dsr_q, dsr_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RADIX_W:0]   shifted;
  logic [RADIX_W:0]   diff;
  logic               qbit;

  always_comb begin
    shifted = {rem_q, dvd_q[VALUE_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    qbit    = (shifted >= {1'b0, dsr_q});
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[VALUE_W-2:0], qbit};
      rem_d  = qbit ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(VALUE_W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_start_idle, start_i |-> !busy_q, "divider started while busy")
  `ASSERT_CLK(a_done_end, done_q |-> $past(busy_q) && !busy_q, "done without a finished division")

endmodule

`default_nettype wire

// ===== bench/signed_integer_to_digit_string_tb.sv =====
`default_nettype none

module signed_integer_to_digit_string_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sitd_pkg::*;

  localparam int unsigned DIGIT_LIMIT = 32;
  localparam int unsigned BASE_LIMIT  = 16;
  localparam int unsigned NUM_RANDOM  = 380;
  localparam int unsigned TAIL_CYCLES = 1300;

  typedef struct packed {
    logic [4:0]  radix;
    logic [31:0] value;
  } number_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  number_req_t pending_numbers[$];
  text_char_t  expected_chars[$];
  int unsigned total_numbers;
  int unsigned numbers_accepted;
  int unsigned chars_checked;
  int unsigned negatives_seen;
  int unsigned clamped_radixes;
  int unsigned error_count;

  signed_integer_to_digit_string i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Three idle phases, advanced by the share of requests already taken.
  function automatic int unsigned idle_phase();
    if (total_numbers == 0) begin
      return 0;
    end
    return (numbers_accepted * 3) / total_numbers;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (idle_phase())
      0: return 10;
      1: return 82;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case (idle_phase())
      0: return 82;
      1: return 10;
      default: return 0;
    endcase
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    expected_chars.push_back(c);
  endfunction

  // Queue the characters that one number should print as.
  function automatic void predict_digit_string(input logic [31:0] value,
                                               input logic [4:0] radix_in);
    logic [31:0] mag;
    logic [5:0]  digit_buf[DIGIT_LIMIT];
    int unsigned base;
    int          n;
    base = radix_in;
    if (base < 2) begin
      base = 2;
    end
    if (base > BASE_LIMIT) begin
      base = BASE_LIMIT;
    end
    if (base != radix_in) begin
      clamped_radixes++;
    end
    mag = value[31] ? (32'd0 - value) : value;
    if (mag == 32'd0) begin
      push_char(CH_ZERO, 1'b0);
      push_char(CH_LF, 1'b1);
      return;
    end
    if (value[31]) begin
      negatives_seen++;
      push_char(CH_MINUS, 1'b0);
    end
    n = 0;
    while (mag != 32'd0 && n < DIGIT_LIMIT) begin
      digit_buf[n] = 6'(mag % base);
      mag = mag / base;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (digit_buf[i] < 6'd10) begin
        push_char(CH_ZERO + CHAR_W'(digit_buf[i]), 1'b0);
      end else begin
        push_char(CH_ALPHA + CHAR_W'(digit_buf[i] - 6'd10), 1'b0);
      end
    end
    push_char(CH_LF, 1'b1);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(99) / 10)
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: begin
        v = $urandom_range(1000);
        if ($urandom_range(1)) begin
          v = 32'd0 - v;
        end
      end
      7, 8: v = $urandom >> $urandom_range(31);
      default: begin
        case ($urandom_range(5))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'd1 << $urandom_range(31);
          default: v = 32'd0 - (32'd1 << $urandom_range(31));
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void add_number(input logic [31:0] value, input logic [4:0] radix);
    number_req_t r;
    r.value = value;
    r.radix = radix;
    pending_numbers.push_back(r);
  endfunction

  // Request driver: holds a request until taken, then maybe idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_digit_string(s_tdata[31:0], s_tdata[36:32]);
        numbers_accepted++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_numbers.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, pending_numbers.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Character monitor and output backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: expected none, got %0d (last %0b)", m_tdata, m_tlast);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (m_tdata !== {1'b0, want.code}) begin
            $error("char_code: expected %0d, got %0d", want.code, m_tdata);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  initial begin
    // corner numbers: zero, extremes, letters, clamped radixes
    add_number(32'd0, 5'd10);
    add_number(32'd0, 5'd0);
    add_number(32'd0, 5'd31);
    add_number(32'h8000_0000, 5'd2);
    add_number(32'h8000_0000, 5'd16);
    add_number(32'h8000_0000, 5'd10);
    add_number(32'h7FFF_FFFF, 5'd2);
    add_number(32'h7FFF_FFFF, 5'd16);
    add_number(32'h7FFF_FFFF, 5'd10);
    add_number(32'hFFFF_FFFF, 5'd10);
    add_number(32'hFFFF_FFFF, 5'd16);
    add_number(32'd1, 5'd0);
    add_number(32'd255, 5'd1);
    add_number(32'd255, 5'd17);
    add_number(32'd255, 5'd31);
    add_number(32'h00AB_CDEF, 5'd16);
    add_number(32'd35, 5'd15);
    add_number(32'd1000, 5'd10);
    add_number(32'd0 - 32'd1000, 5'd3);
    add_number(32'd12345678, 5'd7);
    add_number(32'd9, 5'd9);
    add_number(32'd0 - 32'd15, 5'd16);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      add_number(random_value(), 5'($urandom_range(31)));
    end
    total_numbers = pending_numbers.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_accepted < total_numbers || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative, %0d with clamped radix) into %0d characters.",
             numbers_accepted, negatives_seen, clamped_radixes, chars_checked);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timed out with %0d of %0d numbers taken.", numbers_accepted, total_numbers);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
